// ===== src/rbo_pkg.sv =====
package rbo_pkg;

  // Store and sine table sizes.
  localparam int MAX_BOXES        = 64;
  localparam int SINE_TABLE_DEPTH = 256;

  // Derived widths.
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int SIN_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

  // Fixed field and datapath widths.
  localparam int COORD_W       = 32;
  localparam int SCALE_W       = 16;
  localparam int ANGLE_W       = 16;
  localparam int PHASE_W       = 14;
  localparam int SIN_W         = 17;
  localparam int EXT_W         = 31;
  localparam int PROD_W        = 48;
  localparam int RAD_W         = 32;
  localparam int FRAC_SHIFT    = 16;
  localparam int INDEX_FIELD_W = 6;
  localparam int IN_TDATA_W    = 144;
  localparam int OUT_TDATA_W   = 16;

  // Taylor series constants for the quarter-wave table (Q2.30).
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV_1 = 64'd6;
  localparam logic [63:0] TAYLOR_DIV_2 = 64'd20;
  localparam logic [63:0] TAYLOR_DIV_3 = 64'd42;
  localparam logic [63:0] TAYLOR_DIV_4 = 64'd72;
  localparam logic [63:0] TAYLOR_DIV_5 = 64'd110;
  localparam logic [63:0] TAYLOR_DIV_6 = 64'd156;
  localparam logic [63:0] TAYLOR_DIV_7 = 64'd210;
  localparam logic signed [63:0] SINE_ONE = 64'sd65536;

  // One input box.
  typedef struct packed {
    logic [ANGLE_W-1:0]        angle;
    logic [SCALE_W-1:0]        collider_scale_y;
    logic [SCALE_W-1:0]        collider_scale_x;
    logic [SCALE_W-1:0]        body_scale_y;
    logic [SCALE_W-1:0]        body_scale_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_x;
  } item_t;

  // Stored corners of one box; low x sits in the lowest bits.
  typedef struct packed {
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] lo_x;
  } box_t;

  // Corner pipeline result.
  typedef struct packed {
    logic done;
    box_t box;
  } geom_res_t;

  // Scan request from the sequencer.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
  } scan_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEOM,
    ST_SCAN
  } top_state_t;

  // One quarter-wave sine entry in Q1.16, built from a truncating Taylor series.
  function automatic logic [SIN_W-1:0] sine_entry(input int i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x    = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / TAYLOR_DIV_1;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / TAYLOR_DIV_2;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / TAYLOR_DIV_3;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / TAYLOR_DIV_4;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / TAYLOR_DIV_5;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / TAYLOR_DIV_6;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / TAYLOR_DIV_7;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd8192) >>> 14;
    if (v > SINE_ONE) begin
      v = SINE_ONE;
    end
    return SIN_W'(v);
  endfunction

endpackage

// ===== src/rbo_ram.sv =====
module rbo_ram #(
  parameter int DATA_W = 128,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/rbo_geom.sv =====
module rbo_geom (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rbo_pkg::item_t     item,
  output rbo_pkg::geom_res_t res
);

  logic [rbo_pkg::PHASE_W-1:0]                 phase;
  logic [rbo_pkg::PHASE_W+rbo_pkg::SIN_IDX_W-1:0] idx_prod;
  logic [rbo_pkg::SIN_IDX_W-1:0]               idx_a;
  logic [rbo_pkg::SIN_IDX_W-1:0]               idx_b;
  logic [rbo_pkg::SIN_W-1:0]                   tab_a;
  logic [rbo_pkg::SIN_W-1:0]                   tab_b;
  logic [2*rbo_pkg::SCALE_W-1:0]               half_x;
  logic [2*rbo_pkg::SCALE_W-1:0]               half_y;
  logic [rbo_pkg::SIN_W-1:0]                   sine_rom [0:rbo_pkg::SINE_TABLE_DEPTH];

  // Stage 1: half extents, table lookups.
  logic                                v1_r;
  logic                                rot1_r;
  logic signed [rbo_pkg::COORD_W-1:0]  cx1_r, cy1_r;
  logic [rbo_pkg::EXT_W-1:0]           ex1_r, ey1_r;
  logic [rbo_pkg::SIN_W-1:0]           sin1_r, cos1_r;

  // Stage 2: rotation products.
  logic                                v2_r;
  logic                                rot2_r;
  logic signed [rbo_pkg::COORD_W-1:0]  cx2_r, cy2_r;
  logic [rbo_pkg::EXT_W-1:0]           ex2_r, ey2_r;
  logic [rbo_pkg::PROD_W-1:0]          pxc2_r, pys2_r, pxs2_r, pyc2_r;

  // Stage 3: rotated half extents.
  logic                                v3_r;
  logic signed [rbo_pkg::COORD_W-1:0]  cx3_r, cy3_r;
  logic [rbo_pkg::RAD_W-1:0]           rx3_r, ry3_r;

  // Stage 4: corners.
  logic                                v4_r;
  rbo_pkg::box_t                       box_r;

  logic [rbo_pkg::PROD_W:0]            sum_x, sum_y;
  logic signed [rbo_pkg::COORD_W+1:0]  lo_x_w, lo_y_w, hi_x_w, hi_y_w;

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [rbo_pkg::COORD_W-1:0] sat32(
    input logic signed [rbo_pkg::COORD_W+1:0] v
  );
    logic signed [rbo_pkg::COORD_W-1:0] r;
    if (v[rbo_pkg::COORD_W+1:rbo_pkg::COORD_W-1] == 3'b000 ||
        v[rbo_pkg::COORD_W+1:rbo_pkg::COORD_W-1] == 3'b111) begin
      r = v[rbo_pkg::COORD_W-1:0];
    end else if (v[rbo_pkg::COORD_W+1]) begin
      r = {1'b1, {(rbo_pkg::COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(rbo_pkg::COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Quarter-wave sine table, a set of constants fixed at elaboration.
  for (genvar g = 0; g <= rbo_pkg::SINE_TABLE_DEPTH; g++) begin : g_sine_rom
    assign sine_rom[g] = rbo_pkg::sine_entry(g);
  end

  // Table index from the phase within the quadrant.
  assign phase    = item.angle[rbo_pkg::PHASE_W-1:0];
  assign idx_prod = (rbo_pkg::PHASE_W + rbo_pkg::SIN_IDX_W)'(phase) *
                    (rbo_pkg::PHASE_W + rbo_pkg::SIN_IDX_W)'(rbo_pkg::SINE_TABLE_DEPTH);
  assign idx_a    = idx_prod[rbo_pkg::PHASE_W +: rbo_pkg::SIN_IDX_W];
  assign idx_b    = rbo_pkg::SIN_IDX_W'(rbo_pkg::SINE_TABLE_DEPTH) - idx_a;
  assign tab_a    = sine_rom[idx_a];
  assign tab_b    = sine_rom[idx_b];
  assign half_x   = (2*rbo_pkg::SCALE_W)'(item.body_scale_x) *
                    (2*rbo_pkg::SCALE_W)'(item.collider_scale_x);
  assign half_y   = (2*rbo_pkg::SCALE_W)'(item.body_scale_y) *
                    (2*rbo_pkg::SCALE_W)'(item.collider_scale_y);

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage 1: odd quadrants swap the roles of sine and cosine.
  always_ff @(posedge clk) begin
    if (start) begin
      cx1_r  <= item.center_x;
      cy1_r  <= item.center_y;
      ex1_r  <= half_x[2*rbo_pkg::SCALE_W-1:1];
      ey1_r  <= half_y[2*rbo_pkg::SCALE_W-1:1];
      rot1_r <= (item.angle != '0);
      if (item.angle[rbo_pkg::PHASE_W]) begin
        sin1_r <= tab_b;
        cos1_r <= tab_a;
      end else begin
        sin1_r <= tab_a;
        cos1_r <= tab_b;
      end
    end
  end

  // Stage 2: four products of extent and |sin|, |cos|.
  always_ff @(posedge clk) begin
    if (v1_r) begin
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
      ex2_r  <= ex1_r;
      ey2_r  <= ey1_r;
      rot2_r <= rot1_r;
      pxc2_r <= rbo_pkg::PROD_W'(ex1_r) * rbo_pkg::PROD_W'(cos1_r);
      pys2_r <= rbo_pkg::PROD_W'(ey1_r) * rbo_pkg::PROD_W'(sin1_r);
      pxs2_r <= rbo_pkg::PROD_W'(ex1_r) * rbo_pkg::PROD_W'(sin1_r);
      pyc2_r <= rbo_pkg::PROD_W'(ey1_r) * rbo_pkg::PROD_W'(cos1_r);
    end
  end

  // Stage 3: bounding half extents of the rotated box.
  assign sum_x = (rbo_pkg::PROD_W+1)'(pxc2_r) + (rbo_pkg::PROD_W+1)'(pys2_r);
  assign sum_y = (rbo_pkg::PROD_W+1)'(pxs2_r) + (rbo_pkg::PROD_W+1)'(pyc2_r);

  always_ff @(posedge clk) begin
    if (v2_r) begin
      cx3_r <= cx2_r;
      cy3_r <= cy2_r;
      if (rot2_r) begin
        rx3_r <= sum_x[rbo_pkg::FRAC_SHIFT +: rbo_pkg::RAD_W];
        ry3_r <= sum_y[rbo_pkg::FRAC_SHIFT +: rbo_pkg::RAD_W];
      end else begin
        rx3_r <= rbo_pkg::RAD_W'(ex2_r);
        ry3_r <= rbo_pkg::RAD_W'(ey2_r);
      end
    end
  end

  // Stage 4: saturated corners; held until the next box reaches this stage.
  assign lo_x_w = (rbo_pkg::COORD_W+2)'(cx3_r) - signed'({2'b00, rx3_r});
  assign lo_y_w = (rbo_pkg::COORD_W+2)'(cy3_r) - signed'({2'b00, ry3_r});
  assign hi_x_w = (rbo_pkg::COORD_W+2)'(cx3_r) + signed'({2'b00, rx3_r});
  assign hi_y_w = (rbo_pkg::COORD_W+2)'(cy3_r) + signed'({2'b00, ry3_r});

  always_ff @(posedge clk) begin
    if (v3_r) begin
      box_r.lo_x <= sat32(lo_x_w);
      box_r.lo_y <= sat32(lo_y_w);
      box_r.hi_x <= sat32(hi_x_w);
      box_r.hi_y <= sat32(hi_y_w);
    end
  end

  assign res.done = v4_r;
  assign res.box  = box_r;

endmodule

// ===== src/rbo_scan.sv =====
module rbo_scan (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rbo_pkg::scan_req_t                req,
  input  rbo_pkg::box_t                     box,
  output logic                              done,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rbo_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);

  rbo_pkg::box_t                 rd_box;
  logic [$bits(rbo_pkg::box_t)-1:0] rd_data;

  logic                          active_r;
  logic [rbo_pkg::CNT_W-1:0]     n_r;
  logic [rbo_pkg::CNT_W-1:0]     issue_k_r;
  logic                          cmp_vld_r;
  logic [rbo_pkg::IDX_W-1:0]     cmp_idx_r;
  logic                          pend_vld_r;
  logic [rbo_pkg::IDX_W-1:0]     pend_idx_r;
  logic                          out_vld_r;
  logic [rbo_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                          out_last_r;

  logic stall;
  logic step;
  logic issuing;
  logic finishing;
  logic match;
  logic push_mid;
  logic push_fin;
  logic rd_en;

  // Corner store: entry n is written when its scan starts, entries below n are read.
  rbo_ram #(
    .DATA_W ($bits(rbo_pkg::box_t)),
    .DEPTH  (rbo_pkg::MAX_BOXES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.start),
    .wr_addr (req.n[rbo_pkg::IDX_W-1:0]),
    .wr_data (box),
    .rd_en   (rd_en),
    .rd_addr (issue_k_r[rbo_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_box = rd_data;

  // The scan freezes while a full output register is not being taken.
  assign stall     = out_vld_r && !out_tready;
  assign step      = active_r && !stall;
  assign issuing   = (issue_k_r < n_r);
  assign finishing = !issuing && !cmp_vld_r;
  assign rd_en     = step && issuing;

  // Strict overlap on both axes.
  assign match = cmp_vld_r &&
                 (rd_box.hi_x > box.lo_x) && (rd_box.hi_y > box.lo_y) &&
                 (rd_box.lo_x < box.hi_x) && (rd_box.lo_y < box.hi_y);

  // A found pair waits as pending until the next match or the end shows if it is last.
  assign push_mid = step && match && pend_vld_r;
  assign push_fin = step && finishing && pend_vld_r;
  assign done     = step && finishing;

  // Scan control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      cmp_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else if (req.start) begin
      active_r   <= 1'b1;
      cmp_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else if (step) begin
      cmp_vld_r <= issuing;
      if (finishing) begin
        active_r   <= 1'b0;
        pend_vld_r <= 1'b0;
      end else if (match) begin
        pend_vld_r <= 1'b1;
      end
    end
  end

  // Scan addresses and indexes.
  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r       <= req.n;
      issue_k_r <= '0;
    end else if (step) begin
      if (issuing) begin
        issue_k_r <= issue_k_r + 1'b1;
        cmp_idx_r <= issue_k_r[rbo_pkg::IDX_W-1:0];
      end
      if (match) begin
        pend_idx_r <= cmp_idx_r;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (push_mid || push_fin) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_fin) begin
      out_data_r <= {(rbo_pkg::OUT_TDATA_W - 2*rbo_pkg::INDEX_FIELD_W)'(0),
                     rbo_pkg::INDEX_FIELD_W'(n_r),
                     rbo_pkg::INDEX_FIELD_W'(pend_idx_r)};
      out_last_r <= push_fin;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/rotated_box_overlap_pairs_top.sv =====
// Channel | Direction | tdata (low bit up)                                   | tuser     | tlast
// in_     | slave     | center_x, center_y, body_scale_x/y, collider_scale_x/y, angle | new_frame | -
// out_    | master    | first_index, second_index, zero fill                 | -         | last
//
// A box goes from its request through the corner pipeline, whose result is written into the store,
// then one corner-store read per stored box (n being the boxes already stored in the frame), a
// final compare and a closing step before the next box is taken.
// The 1W1R store is read once per cycle unless stalled; the sequencer stays idle for a dropped box.
// Reset is synchronous and clears the box count; the store needs no clearing pass.
// A stalled output freezes the scan; the next box is taken while the last pair waits.
module rotated_box_overlap_pairs_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // center_x[31:0], center_y[63:32], body_scale_x[79:64], body_scale_y[95:80],
  // collider_scale_x[111:96], collider_scale_y[127:112], angle[143:128]
  input  logic [rbo_pkg::IN_TDATA_W-1:0]  in_tdata,
  // new_frame[0]
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // first_index[5:0], second_index[11:6], zero[15:12]
  output logic [rbo_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready
);

  rbo_pkg::top_state_t       state_r, state_nxt;
  logic [rbo_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [rbo_pkg::CNT_W-1:0] n_r, n_nxt;
  logic [rbo_pkg::CNT_W-1:0] count_eff;
  logic                      accept;
  logic                      drop;
  logic                      geom_start;
  logic                      scan_done;
  rbo_pkg::item_t            item;
  rbo_pkg::geom_res_t        geom_res;
  rbo_pkg::scan_req_t        scan_req;

  assign item      = in_tdata;
  assign accept    = in_tvalid && in_tready;
  assign count_eff = in_tuser ? '0 : count_r;
  assign drop      = (count_eff == rbo_pkg::CNT_W'(rbo_pkg::MAX_BOXES));

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbo_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
  end

  // Next state: take a box (or drop it when the store is full), run its corners, then scan the store.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    n_nxt          = n_r;
    in_tready      = 1'b0;
    geom_start     = 1'b0;
    scan_req.start = 1'b0;
    scan_req.n     = n_r;
    case (state_r)
      rbo_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          count_nxt = count_eff;
          if (!drop) begin
            geom_start = 1'b1;
            n_nxt      = count_eff;
            state_nxt  = rbo_pkg::ST_GEOM;
          end
        end
      end
      rbo_pkg::ST_GEOM: begin
        if (geom_res.done) begin
          scan_req.start = 1'b1;
          count_nxt      = n_r + 1'b1;
          state_nxt      = rbo_pkg::ST_SCAN;
        end
      end
      rbo_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = rbo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbo_pkg::ST_IDLE;
      end
    endcase
  end

  rbo_geom u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .start (geom_start),
    .item  (item),
    .res   (geom_res)
  );

  rbo_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (scan_req),
    .box        (geom_res.box),
    .done       (scan_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/rbo_checker.sv =====
module rbo_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tuser,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [rbo_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready
);

  // A waiting pair holds still.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output pair changed");

  // The earlier box always has the lower index.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] < out_tdata[11:6]))
    else $error("pair indexes out of order");

  // A box opening a frame is always stored, so the block is busy next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("new frame box was not processed");

  // A pair that is not the last of its box means the scan is still running.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken before all pairs of a box were found");

endmodule

bind rotated_box_overlap_pairs_top rbo_checker u_rbo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ===== sim/tb_rotated_box_overlap_pairs_top.sv =====
module tb_rotated_box_overlap_pairs_top;

  // Run shape.
  localparam int ITEM_TARGET   = 170;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD_OFF = 400;
  localparam int SINE_STEPS    = rbo_pkg::SINE_TABLE_DEPTH;
  localparam int STORE_DEPTH   = rbo_pkg::MAX_BOXES;

  // Quarter turn in Q2.30, used to build the sine table.
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  // Common coordinate and scale values in Q16.16 and Q8.8.
  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [31:0] HALF_Q16  = 32'h0000_8000;
  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [15:0] SCALE_ONE = 16'h0100;
  localparam logic [15:0] SCALE_MAX = 16'hFFFF;

  // One request on the input channel.
  typedef struct {
    rbo_pkg::item_t shape;
    logic           new_frame;
  } box_req_t;

  // One overlap pair on the output channel.
  typedef struct packed {
    logic [5:0] earlier;
    logic [5:0] newer;
    logic       last;
  } pair_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic [rbo_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            in_tuser   = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [rbo_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;

  // Predictor state: sine table, stored corners and box count of the frame.
  logic [16:0] quarter_sine [0:SINE_STEPS];
  longint      corner_lo_x [0:STORE_DEPTH-1];
  longint      corner_lo_y [0:STORE_DEPTH-1];
  longint      corner_hi_x [0:STORE_DEPTH-1];
  longint      corner_hi_y [0:STORE_DEPTH-1];
  int          stored_boxes = 0;

  pair_t expected_pairs [$];
  int    error_count    = 0;
  int    boxes_accepted = 0;
  int    burst_left     = 0;
  int    hold_off_request = 0;

  rotated_box_overlap_pairs_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Clock with a period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Build |sin| over a quarter wave with a truncating Taylor series in Q2.30.
  function automatic void build_quarter_sine();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int i = 0; i <= SINE_STEPS; i++) begin
      x    = (64'(i) * QUARTER_TURN_Q30) / 64'(SINE_STEPS);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (longint'(sum) + 8192) >> 14;
      if (v > 65536) begin
        v = 65536;
      end
      quarter_sine[i] = v[16:0];
    end
  endfunction

  // Saturate a corner coordinate to signed 32 bits.
  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Work out the pairs one accepted box causes and store its corners.
  function automatic void predict_pairs(box_req_t b);
    longint          cx;
    longint          cy;
    longint          ext_x;
    longint          ext_y;
    longint          rad_x;
    longint          rad_y;
    longint          lo_x;
    longint          lo_y;
    longint          hi_x;
    longint          hi_y;
    longint          sin_v;
    longint          cos_v;
    int              step;
    pair_t           hit;
    pair_t           found [$];
    if (b.new_frame) begin
      stored_boxes = 0;
    end
    // A full store drops the box without any result.
    if (stored_boxes >= STORE_DEPTH) begin
      return;
    end
    cx    = longint'(signed'(b.shape.center_x));
    cy    = longint'(signed'(b.shape.center_y));
    ext_x = (longint'(b.shape.body_scale_x) * longint'(b.shape.collider_scale_x)) >>> 1;
    ext_y = (longint'(b.shape.body_scale_y) * longint'(b.shape.collider_scale_y)) >>> 1;
    if (b.shape.angle != '0) begin
      // Odd quadrants swap the roles of the two table reads.
      step = int'(b.shape.angle[13:6]);
      if (b.shape.angle[14]) begin
        sin_v = longint'(quarter_sine[SINE_STEPS - step]);
        cos_v = longint'(quarter_sine[step]);
      end else begin
        sin_v = longint'(quarter_sine[step]);
        cos_v = longint'(quarter_sine[SINE_STEPS - step]);
      end
      rad_x = (ext_x * cos_v + ext_y * sin_v) >>> 16;
      rad_y = (ext_x * sin_v + ext_y * cos_v) >>> 16;
    end else begin
      rad_x = ext_x;
      rad_y = ext_y;
    end
    lo_x = clamp_coord(cx - rad_x);
    lo_y = clamp_coord(cy - rad_y);
    hi_x = clamp_coord(cx + rad_x);
    hi_y = clamp_coord(cy + rad_y);
    // Strict overlap on both axes against every earlier box of the frame.
    for (int k = 0; k < stored_boxes; k++) begin
      if (corner_hi_x[k] > lo_x && corner_hi_y[k] > lo_y &&
          corner_lo_x[k] < hi_x && corner_lo_y[k] < hi_y) begin
        hit.earlier = 6'(k);
        hit.newer   = 6'(stored_boxes);
        hit.last    = 1'b0;
        found.push_back(hit);
      end
    end
    if (found.size() != 0) begin
      found[found.size() - 1].last = 1'b1;
    end
    foreach (found[j]) begin
      expected_pairs.push_back(found[j]);
    end
    corner_lo_x[stored_boxes] = lo_x;
    corner_lo_y[stored_boxes] = lo_y;
    corner_hi_x[stored_boxes] = hi_x;
    corner_hi_y[stored_boxes] = hi_y;
    stored_boxes++;
  endfunction

  function automatic box_req_t make_box(logic [31:0] cx, logic [31:0] cy,
                                        logic [15:0] bsx, logic [15:0] bsy,
                                        logic [15:0] csx, logic [15:0] csy,
                                        logic [15:0] ang, logic nf);
    box_req_t b;
    b.shape.center_x         = cx;
    b.shape.center_y         = cy;
    b.shape.body_scale_x     = bsx;
    b.shape.body_scale_y     = bsy;
    b.shape.collider_scale_x = csx;
    b.shape.collider_scale_y = csy;
    b.shape.angle            = ang;
    b.new_frame              = nf;
    return b;
  endfunction

  // Box near the origin with a moderate size, so that overlaps are common.
  function automatic box_req_t cluster_box(logic nf, int unsigned spread);
    logic [31:0] cx;
    logic [31:0] cy;
    logic [15:0] ang;
    cx  = 32'($urandom_range(2 * spread, 0)) - 32'(spread);
    cy  = 32'($urandom_range(2 * spread, 0)) - 32'(spread);
    ang = ($urandom_range(1, 0) == 0) ? 16'h0000 : 16'($urandom);
    return make_box(cx, cy, 16'($urandom_range(640, 128)), 16'($urandom_range(640, 128)),
                    16'($urandom_range(640, 128)), 16'($urandom_range(640, 128)),
                    ang, nf);
  endfunction

  // Box with every field drawn over its whole range.
  function automatic box_req_t noise_box();
    return make_box(32'($urandom), 32'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endfunction

  // Send one request in bursts, with random gaps between bursts.
  task automatic send_box(box_req_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3, 0) == 0) ? 40 : $urandom_range(12, 1);
      gap        = $urandom_range(6, 0);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b.shape;
    in_tuser  <= b.new_frame;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    predict_pairs(b);
    boxes_accepted++;
  endtask

  // Stop offering and wait until every expected pair has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_pairs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Field extremes, every rotation quadrant, touching edges, saturation and frames.
  task automatic test_directed();
    send_box(make_box(32'h0, 32'h0, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE, 16'h0, 1'b1));
    send_box(make_box(32'h0, 32'h0, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE, 16'h0, 1'b0));
    // Edges that only touch do not overlap.
    send_box(make_box(ONE_Q16, 32'h0, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE,
                      16'h0, 1'b0));
    send_box(make_box(HALF_Q16, 32'h0, 16'h0200, SCALE_ONE, SCALE_ONE, SCALE_ONE,
                      16'h4000, 1'b0));
    send_box(make_box(32'h0, HALF_Q16, 16'h0200, 16'h0180, SCALE_ONE, 16'h0300,
                      16'h2000, 1'b0));
    send_box(make_box(ONE_Q16, ONE_Q16, 16'h0300, SCALE_ONE, SCALE_ONE, SCALE_ONE,
                      16'h8000, 1'b0));
    send_box(make_box(-ONE_Q16, ONE_Q16, 16'h0300, SCALE_ONE, SCALE_ONE, SCALE_ONE,
                      16'hC000, 1'b0));
    send_box(make_box(-HALF_Q16, -ONE_Q16, 16'h0300, 16'h0080, SCALE_ONE, SCALE_ONE,
                      16'hFFFF, 1'b0));
    send_box(make_box(32'h0, 32'h0, 16'h0400, SCALE_ONE, SCALE_ONE, SCALE_ONE,
                      16'h0001, 1'b0));
    // Zero scales give a point box.
    send_box(make_box(32'h0, 32'h0, 16'h0, 16'h0, SCALE_ONE, SCALE_ONE, 16'h0, 1'b0));
    send_box(make_box(HALF_Q16, 32'h0, SCALE_MAX, SCALE_MAX, 16'h0, 16'h0, 16'h3FFF, 1'b0));
    // Corner sums that saturate in both directions.
    send_box(make_box(COORD_MAX, COORD_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX,
                      16'h0, 1'b0));
    send_box(make_box(COORD_MIN, COORD_MIN, SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX,
                      16'h2000, 1'b0));
    send_box(make_box(32'h0, 32'h0, SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX,
                      16'h2000, 1'b0));
    // A new frame in the middle forgets the boxes before it.
    send_box(make_box(32'h0, 32'h0, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE, 16'h0, 1'b1));
    send_box(make_box(32'h0, 32'h0, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE, 16'h0, 1'b0));
    send_box(make_box(32'h0, 32'h0, SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX,
                      16'hE000, 1'b1));
    send_box(make_box(COORD_MIN, COORD_MAX, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE,
                      16'h0, 1'b0));
    send_box(make_box(32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_box(make_box(32'h0, 32'h0, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE, 16'h0, 1'b1));
    send_box(make_box(32'h0, 32'h0, SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE, 16'h0, 1'b1));
    send_box(make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, SCALE_MAX, SCALE_MAX, SCALE_ONE,
                      SCALE_ONE, 16'hFFFF, 1'b0));
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_back_pressure();
    hold_off_request = LONG_HOLD_OFF;
    burst_left       = 40;
    for (int i = 0; i < 12; i++) begin
      send_box(cluster_box(i == 0, 262144));
    end
    wait_drained();
  endtask

  // Fill one frame past capacity; the extra boxes are dropped.
  task automatic test_store_full();
    for (int i = 0; i < STORE_DEPTH + 3; i++) begin
      send_box(cluster_box(i == 0, 8 * 65536));
    end
    send_box(cluster_box(1'b1, 262144));
    wait_drained();
  endtask

  // Random frames of clustered boxes with some noise mixed in.
  task automatic test_random_frames();
    int frame_len;
    while (boxes_accepted < ITEM_TARGET) begin
      frame_len = $urandom_range(16, 1);
      for (int i = 0; i < frame_len; i++) begin
        if ($urandom_range(99, 0) < 15) begin
          send_box(noise_box());
        end else begin
          send_box(cluster_box(i == 0, 262144));
        end
      end
      if ($urandom_range(3, 0) == 0) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  // Receiver readiness: random runs of ready and stall, plus long hold-offs on request.
  always @(negedge clk) begin : result_receiver
    static int run_left  = 0;
    static int hold_left = 0;
    static bit run_ready = 1'b1;
    int pick;
    if (hold_off_request != 0) begin
      hold_left        = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        pick = $urandom_range(9, 0);
        if (pick < 5) begin
          run_ready = 1'b1;
          run_left  = $urandom_range(16, 1);
        end else if (pick < 8) begin
          run_ready = 1'b0;
          run_left  = $urandom_range(5, 1);
        end else begin
          run_ready = 1'b1;
          run_left  = $urandom_range(80, 40);
        end
      end
      run_left--;
      out_tready <= run_ready;
    end
  end

  // Compare each accepted pair with the oldest expected one.
  always @(posedge clk) begin : pair_checker
    pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected pair, expected none, got earlier %0d newer %0d last %0b",
                 $time, out_tdata[5:0], out_tdata[11:6], out_tlast);
        error_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_tdata[5:0] !== want.earlier) begin
          $display("%0t: first_index mismatch, expected %0d, got %0d",
                   $time, want.earlier, out_tdata[5:0]);
          error_count++;
        end
        if (out_tdata[11:6] !== want.newer) begin
          $display("%0t: second_index mismatch, expected %0d, got %0d",
                   $time, want.newer, out_tdata[11:6]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles with no request moving on either side.
  always @(posedge clk) begin : stall_watchdog
    static int quiet_cycles = 0;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d pairs still expected", $time, expected_pairs.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    build_quarter_sine();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_back_pressure();
    test_store_full();
    test_random_frames();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pairs.size() != 0) begin
      $display("%0t: %0d expected pairs never arrived", $time, expected_pairs.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
